/* design/vn3_pkg.sv */
// Shared constants and types for the 3D vector normalize core.
package vn3_pkg;
  localparam int FRAC_BITS = 12;
  localparam int EPS_WIDTH = 15;

  // Valid and scaled status handed to the merge stage.
  typedef struct packed {
    logic valid;
    logic scaled;
  } vn3_lane_stat_t;
endpackage

/* design/vn3_sqrt.sv */
// Pipelined integer square root of the sum of squares, one result bit per stage.
module vn3_sqrt #(
  parameter int SUM_W = 34,
  parameter int ROOT_W = 17
) (
  input  logic              clk,
  input  logic              en,
  input  logic [SUM_W-1:0]  sum_i,
  output logic [ROOT_W-1:0] root_o
);
  import vn3_pkg::*;

  localparam int RW = 2 * ROOT_W;

  logic [RW-1:0]     rem_r  [ROOT_W+1];
  logic [ROOT_W-1:0] root_r [ROOT_W+1];

  always_comb begin
    rem_r[0]  = RW'(sum_i);
    root_r[0] = '0;
  end

  // Stage k decides bit ROOT_W-1-k of the root (restoring method).
  for (genvar k = 0; k < ROOT_W; k++) begin : g_stage
    localparam int B = ROOT_W - 1 - k;
    logic [RW-1:0]     trial;
    logic [RW-1:0]     rem_nxt;
    logic [ROOT_W-1:0] root_nxt;
    logic [RW-1:0]     rem_q;
    logic [ROOT_W-1:0] root_q;
    always_comb begin
      trial = (RW'(root_r[k]) << (B + 1)) | (RW'(1) << (2 * B));
      if (rem_r[k] >= trial) begin
        rem_nxt  = rem_r[k] - trial;
        root_nxt = root_r[k] | (ROOT_W'(1) << B);
      end else begin
        rem_nxt  = rem_r[k];
        root_nxt = root_r[k];
      end
    end
    always_ff @(posedge clk) begin
      if (en) begin
        rem_q  <= rem_nxt;
        root_q <= root_nxt;
      end
    end
    always_comb begin
      rem_r[k+1]  = rem_q;
      root_r[k+1] = root_q;
    end
  end

  assign root_o = root_r[ROOT_W];
endmodule

/* design/vn3_div_lane.sv */
// One divider lane: pipelined signed component / magnitude with saturation, or the raw component when not scaled.
module vn3_div_lane #(
  parameter int COMP_WIDTH = 16,
  parameter int ROOT_W = 17
) (
  input  logic                         clk,
  input  logic                         en,
  input  logic signed [COMP_WIDTH-1:0] comp_i,
  input  logic [ROOT_W-1:0]            mag_i,
  input  logic                         scale_i,
  output logic signed [COMP_WIDTH-1:0] res_o
);
  import vn3_pkg::*;

  // quotient never exceeds 1.0 in Q.FRAC, so it needs FRAC_BITS+1 bits at least
  localparam int QW = (COMP_WIDTH > FRAC_BITS) ? COMP_WIDTH + 1 : FRAC_BITS + 1;
  localparam int NW = COMP_WIDTH + FRAC_BITS;  // dividend width
  localparam int RMW = ROOT_W + 1;
  localparam logic [QW-1:0] MAXPOS = QW'((2 ** (COMP_WIDTH - 1)) - 1);

  logic [NW-1:0]         num_r  [QW+1];
  logic [RMW-1:0]        rem_r  [QW+1];
  logic [QW-1:0]         quo_r  [QW+1];
  logic [ROOT_W-1:0]     den_r  [QW+1];
  logic                  neg_r  [QW+1];
  logic                  scl_r  [QW+1];
  logic [COMP_WIDTH-1:0] raw_r  [QW+1];

  logic [COMP_WIDTH-1:0] abs_c;
  assign abs_c = comp_i[COMP_WIDTH-1] ? COMP_WIDTH'(-comp_i) : COMP_WIDTH'(comp_i);

  // Top NW-QW dividend bits are below the divisor, seed remainder with them.
  always_comb begin
    num_r[0] = {abs_c, {FRAC_BITS{1'b0}}};
    rem_r[0] = RMW'(num_r[0] >> QW);
    quo_r[0] = '0;
    den_r[0] = mag_i;
    neg_r[0] = comp_i[COMP_WIDTH-1];
    scl_r[0] = scale_i;
    raw_r[0] = comp_i;
  end

  for (genvar k = 0; k < QW; k++) begin : g_stage
    localparam int B = QW - 1 - k;
    logic [RMW-1:0] sh;
    logic [RMW-1:0] rem_nxt;
    logic           qbit;
    logic [NW-1:0]         num_q;
    logic [RMW-1:0]        rem_q;
    logic [QW-1:0]         quo_q;
    logic [ROOT_W-1:0]     den_q;
    logic                  neg_q, scl_q;
    logic [COMP_WIDTH-1:0] raw_q;
    always_comb begin
      sh = {rem_r[k][RMW-2:0], num_r[k][B]};
      qbit = (sh >= RMW'(den_r[k])) && (den_r[k] != '0);
      rem_nxt = qbit ? sh - RMW'(den_r[k]) : sh;
    end
    always_ff @(posedge clk) begin
      if (en) begin
        num_q <= num_r[k];
        rem_q <= rem_nxt;
        quo_q <= quo_r[k] | (QW'(qbit) << B);
        den_q <= den_r[k];
        neg_q <= neg_r[k];
        scl_q <= scl_r[k];
        raw_q <= raw_r[k];
      end
    end
    always_comb begin
      num_r[k+1] = num_q;
      rem_r[k+1] = rem_q;
      quo_r[k+1] = quo_q;
      den_r[k+1] = den_q;
      neg_r[k+1] = neg_q;
      scl_r[k+1] = scl_q;
      raw_r[k+1] = raw_q;
    end
  end

  logic [QW-1:0] q_sat;
  always_comb begin
    q_sat = (quo_r[QW] > MAXPOS) ? MAXPOS : quo_r[QW];
    if (!scl_r[QW]) begin
      res_o = raw_r[QW];
    end else if (neg_r[QW]) begin
      res_o = COMP_WIDTH'(-q_sat);
    end else begin
      res_o = COMP_WIDTH'(q_sat);
    end
  end
endmodule

/* design/vector3_normalize_core.sv */
// Top level: squares, root pipeline, three divider lanes and output merge.
// Pipeline order: square stage, root stages, compare stage, divide stages, output register.
// Throughput: one vector per cycle; the whole pipe advances when the output
// register is empty or being taken, so stall backs up through every stage.
// Reset: synchronous active-low rst_n clears all valid bits and sets epsilon to 1.
// cfg_ready is always high; epsilon is read at the magnitude compare.
module vector3_normalize_core #(
  parameter int COMP_WIDTH = 16
) (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         in_valid,
  output logic                         in_stall,
  input  logic signed [COMP_WIDTH-1:0] in_comp_x,
  input  logic signed [COMP_WIDTH-1:0] in_comp_y,
  input  logic signed [COMP_WIDTH-1:0] in_comp_z,
  output logic                         out_valid,
  input  logic                         out_stall,
  output logic signed [COMP_WIDTH-1:0] out_x,
  output logic signed [COMP_WIDTH-1:0] out_y,
  output logic signed [COMP_WIDTH-1:0] out_z,
  output logic                         out_scaled,
  input  logic                         cfg_valid,
  output logic                         cfg_ready,
  input  logic [vn3_pkg::EPS_WIDTH-1:0] cfg_epsilon
);
  import vn3_pkg::*;

  localparam int SQ_W = 2 * COMP_WIDTH;
  localparam int SUM_W = SQ_W + 2;
  localparam int ROOT_W = (SUM_W + 1) / 2;
  localparam int QW = (COMP_WIDTH > FRAC_BITS) ? COMP_WIDTH + 1 : FRAC_BITS + 1;
  localparam int SQ_DEPTH = ROOT_W + 1;       // square stage + root stages
  localparam int PIPE = SQ_DEPTH + 1 + QW;    // + compare stage + divide stages

  logic en;
  logic [PIPE-1:0] vld_r;
  logic [EPS_WIDTH-1:0] eps_r;

  assign en = !out_valid || !out_stall;
  assign in_stall = !en;
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      eps_r <= EPS_WIDTH'(1);
    end else if (cfg_valid && cfg_ready) begin
      eps_r <= cfg_epsilon;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else if (en) begin
      vld_r <= {vld_r[PIPE-2:0], in_valid};
    end
  end

  // Square stage: register squares and raw components.
  logic [SQ_W-1:0] sqx_r, sqy_r, sqz_r;
  logic [3*COMP_WIDTH-1:0] raw_d [SQ_DEPTH+1];
  logic [SQ_W-1:0] ax, ay, az;
  assign ax = SQ_W'(in_comp_x[COMP_WIDTH-1] ? -in_comp_x : in_comp_x);
  assign ay = SQ_W'(in_comp_y[COMP_WIDTH-1] ? -in_comp_y : in_comp_y);
  assign az = SQ_W'(in_comp_z[COMP_WIDTH-1] ? -in_comp_z : in_comp_z);
  logic [COMP_WIDTH-1:0] ax_n, ay_n, az_n;
  assign ax_n = ax[COMP_WIDTH-1:0];
  assign ay_n = ay[COMP_WIDTH-1:0];
  assign az_n = az[COMP_WIDTH-1:0];

  always_ff @(posedge clk) begin
    if (en) begin
      sqx_r <= SQ_W'(ax_n) * SQ_W'(ax_n);
      sqy_r <= SQ_W'(ay_n) * SQ_W'(ay_n);
      sqz_r <= SQ_W'(az_n) * SQ_W'(az_n);
    end
  end

  assign raw_d[0] = {in_comp_x, in_comp_y, in_comp_z};
  for (genvar i = 0; i < SQ_DEPTH; i++) begin : g_raw
    logic [3*COMP_WIDTH-1:0] q;
    always_ff @(posedge clk) begin
      if (en) q <= raw_d[i];
    end
    assign raw_d[i+1] = q;
  end

  logic [SUM_W-1:0] sum;
  logic [ROOT_W-1:0] mag;
  assign sum = SUM_W'(sqx_r) + SUM_W'(sqy_r) + SUM_W'(sqz_r);

  vn3_sqrt #(.SUM_W(SUM_W), .ROOT_W(ROOT_W)) u_sqrt (
    .clk(clk), .en(en), .sum_i(sum), .root_o(mag)
  );

  // Compare stage: decide scaling against epsilon.
  logic [ROOT_W-1:0] mag_r;
  logic [3*COMP_WIDTH-1:0] raw_r;
  logic scale_r;
  always_ff @(posedge clk) begin
    if (en) begin
      mag_r   <= mag;
      raw_r   <= raw_d[SQ_DEPTH];
      scale_r <= mag > ROOT_W'(eps_r);
    end
  end

  logic signed [COMP_WIDTH-1:0] res [3];
  logic [COMP_WIDTH-1:0] lane_in [3];
  assign lane_in[0] = raw_r[3*COMP_WIDTH-1:2*COMP_WIDTH];
  assign lane_in[1] = raw_r[2*COMP_WIDTH-1:COMP_WIDTH];
  assign lane_in[2] = raw_r[COMP_WIDTH-1:0];

  for (genvar l = 0; l < 3; l++) begin : g_lane
    vn3_div_lane #(.COMP_WIDTH(COMP_WIDTH), .ROOT_W(ROOT_W)) u_lane (
      .clk(clk), .en(en), .comp_i(lane_in[l]), .mag_i(mag_r),
      .scale_i(scale_r), .res_o(res[l])
    );
  end

  // Scaled flag follows the lanes down the divide pipe.
  logic [QW-1:0] scl_d;
  always_ff @(posedge clk) begin
    if (en) scl_d <= {scl_d[QW-2:0], scale_r};
  end

  // Merge stage into the output register.
  vn3_lane_stat_t stat;
  assign stat.valid  = vld_r[PIPE-1];
  assign stat.scaled = scl_d[QW-1];

  logic out_valid_r;
  logic signed [COMP_WIDTH-1:0] ox_r, oy_r, oz_r;
  logic osc_r;
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (en) begin
      out_valid_r <= stat.valid;
    end
  end
  always_ff @(posedge clk) begin
    if (en) begin
      ox_r  <= res[0];
      oy_r  <= res[1];
      oz_r  <= res[2];
      osc_r <= stat.scaled;
    end
  end

  assign out_valid  = out_valid_r;
  assign out_x      = ox_r;
  assign out_y      = oy_r;
  assign out_z      = oz_r;
  assign out_scaled = osc_r;

  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_x) && $stable(out_scaled))
    else $error("output changed under stall");
  a_stall: assert property (@(posedge clk) disable iff (!rst_n)
    in_stall == (out_valid && out_stall))
    else $error("input stall mismatch");
  a_rst: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("output valid after reset");
endmodule
